// ----- rtl/core/icf_pkg.sv -----
// Package: shared types, sizes and controller states of the inversion counter.
`timescale 1ns / 1ps

package icf_pkg;

  // Sizes of the value space and of the sequence capacity
  localparam int VALUE_BITS = 16;
  localparam int MAX_ITEMS  = 1048576;
  localparam int TREE_SIZE  = 1 << VALUE_BITS;
  localparam int K_BITS     = VALUE_BITS + 1;
  localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

  // Fixed field widths of the channels
  localparam int IN_VALUE_BITS = 16;
  localparam int TOTAL_BITS    = 39;
  localparam int SEEN_BITS     = 21;

  typedef struct packed {
    logic [IN_VALUE_BITS-1:0] value;
    logic                     first;
  } item_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] running_inversions;
    logic [SEEN_BITS-1:0]  items_seen;
    logic                  dropped;
  } result_t;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_SEQ_CLR,
    ST_START,
    ST_QUERY,
    ST_QLAST,
    ST_ACCUM,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_item;
    logic clr_totals;
    logic clr_write;
    logic start;
    logic q_read;
    logic accum;
    logic u_read;
    logic load_out;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic full;
    logic q_last;
    logic u_last;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- rtl/core/icf_ctrl.sv -----
// Controller: sequences clearing sweeps, tree query and tree update per transaction.
`timescale 1ns / 1ps

module icf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_first,
  input  icf_pkg::dp_status_t sts,
  output icf_pkg::ctrl_cmd_t  cmd,
  output logic               item_stall
);
  import icf_pkg::*;

  state_t state;
  state_t state_next;
  logic   take;

  assign take       = item_valid && (state == ST_IDLE);
  assign item_stall = (state != ST_IDLE);

  // Hold state, start with the clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_CLR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT_CLR: begin
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (take) state_next = item_first ? ST_SEQ_CLR : ST_START;
      end
      ST_SEQ_CLR: begin
        if (sts.clr_done) state_next = ST_START;
      end
      ST_START: begin
        state_next = sts.full ? ST_FINISH : ST_QUERY;
      end
      ST_QUERY: begin
        if (sts.q_last) state_next = ST_QLAST;
      end
      ST_QLAST: begin
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.u_last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!sts.out_busy) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT_CLR;
      end
    endcase
  end

  // Command outputs
  always_comb begin
    cmd            = '0;
    cmd.take_item  = take;
    cmd.clr_totals = take && item_first;
    case (state)
      ST_INIT_CLR: cmd.clr_write = 1'b1;
      ST_SEQ_CLR:  cmd.clr_write = 1'b1;
      ST_START:    cmd.start     = 1'b1;
      ST_QUERY:    cmd.q_read    = 1'b1;
      ST_ACCUM:    cmd.accum     = 1'b1;
      ST_UPDATE:   cmd.u_read    = 1'b1;
      ST_FINISH:   cmd.load_out  = !sts.out_busy;
      default:     cmd.clr_write = 1'b0;
    endcase
  end

endmodule

// ----- rtl/core/icf_datapath.sv -----
// Datapath: tree memory, index walker, prefix sum, totals and result register.
`timescale 1ns / 1ps

module icf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  icf_pkg::ctrl_cmd_t  cmd,
  input  icf_pkg::item_t      item,
  output icf_pkg::dp_status_t sts,
  output logic                result_valid,
  input  logic                result_stall,
  output icf_pkg::result_t    result
);
  import icf_pkg::*;

  logic [CNT_BITS-1:0]   tree [TREE_SIZE];

  item_t                 item_q;
  logic [VALUE_BITS-1:0] v;
  logic [K_BITS-1:0]     k;
  logic [K_BITS-1:0]     k_init;
  logic [K_BITS-1:0]     low_bit;
  logic [K_BITS-1:0]     k_down;
  logic [K_BITS:0]       k_up;
  logic [VALUE_BITS-1:0] addr;
  logic [VALUE_BITS-1:0] clr_addr;
  logic [CNT_BITS-1:0]   rd_data;
  logic                  acc_pend;
  logic                  wb_pend;
  logic [VALUE_BITS-1:0] wb_addr;
  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_addr;
  logic [CNT_BITS-1:0]   wr_data;
  logic [CNT_BITS-1:0]   sum;
  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   greater;
  logic [TOTAL_BITS-1:0] total;
  logic                  drop;

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.take_item) item_q <= item;
  end

  // Index arithmetic of the binary indexed tree (tree slot k sits at address k-1)
  assign v       = VALUE_BITS'(item_q.value);
  assign k_init  = {1'b0, v} + K_BITS'(1);
  assign low_bit = k & (~k + K_BITS'(1));
  assign k_down  = k - low_bit;
  assign k_up    = {1'b0, k} + {1'b0, low_bit};
  assign addr    = VALUE_BITS'(k - K_BITS'(1));

  // Walk the tree index down for a query, up for an update
  always_ff @(posedge clk) begin
    if (cmd.start || cmd.accum) begin
      k <= k_init;
    end else if (cmd.q_read) begin
      k <= k_down;
    end else if (cmd.u_read) begin
      k <= K_BITS'(k_up);
    end
  end

  // Track reads whose data must be summed or written back
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
      wb_pend  <= 1'b0;
    end else begin
      acc_pend <= cmd.q_read;
      wb_pend  <= cmd.u_read;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.u_read) wb_addr <= addr;
  end

  // Select the write: clearing sweep or incremented count
  always_comb begin
    wr_en   = cmd.clr_write || wb_pend;
    wr_addr = cmd.clr_write ? clr_addr : wb_addr;
    wr_data = cmd.clr_write ? '0 : rd_data + CNT_BITS'(1);
  end

  // Tree memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) tree[wr_addr] <= wr_data;
    if (cmd.q_read || cmd.u_read) rd_data <= tree[addr];
  end

  // Advance the clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write) begin
      clr_addr <= clr_addr + VALUE_BITS'(1);
    end
  end

  // Accumulate the prefix sum
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sum <= '0;
    end else if (acc_pend) begin
      sum <= sum + rd_data;
    end
  end

  // Update totals: earlier items strictly greater than this value
  assign greater = count - sum;

  always_ff @(posedge clk) begin
    if (rst || cmd.clr_totals) begin
      count <= '0;
      total <= '0;
    end else if (cmd.accum) begin
      count <= count + CNT_BITS'(1);
      total <= total + TOTAL_BITS'(greater);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) drop <= sts.full;
  end

  // Output register, freed when the receiver takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.running_inversions <= total;
      result.items_seen         <= SEEN_BITS'(count);
      result.dropped            <= drop;
    end
  end

  // Status to the controller
  assign sts.clr_done = (clr_addr == '1);
  assign sts.full     = (count >= CNT_BITS'(MAX_ITEMS));
  assign sts.q_last   = (k_down == '0);
  assign sts.u_last   = (k_up > (K_BITS + 1)'(TREE_SIZE));
  assign sts.out_busy = result_valid && result_stall;

endmodule

// ----- rtl/core/inversion_counter_fenwick_core.sv -----
// Top level: inversion counter over a value stream on a binary indexed tree.
//
// Input channel item (value, first) and output channel result (running_inversions,
// items_seen, dropped) use valid/stall; a transaction moves when valid is high and
// stall is low. Each input transaction gives exactly one result transaction.
// A set first flag starts a new sequence: the tree memory is swept to zero, one
// entry a cycle, all 2^VALUE_BITS entries (65536), before the item is processed.
// Per item: the IDLE state accepts it, START begins the walk, one tree read per
// set-bit step of the query (1 to VALUE_BITS reads), QLAST and ACCUM close the sum,
// one read-modify-write per update step (1 to VALUE_BITS+1 steps), and FINISH loads
// the result register. Query and update together take at most VALUE_BITS+2 steps.
// The single tree memory does one index step a cycle, and a new item is accepted
// only back in IDLE. A dropped item goes from START straight to FINISH.
// After reset the block runs the same clearing pass with item_stall high; totals
// start at zero and items without first extend the empty sequence.
// The result register lets the next item be accepted while a result waits; when the
// receiver stalls, the block finishes that next item and then holds until the
// register frees.
`timescale 1ns / 1ps

module inversion_counter_fenwick_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  icf_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output icf_pkg::result_t result
);
  import icf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  icf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_first (item.first),
    .sts        (sts),
    .cmd        (cmd),
    .item_stall (item_stall)
  );

  icf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .sts          (sts),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // An accepted transaction keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input accepted again right after a transaction");

  // A dropped item reports a sequence at full capacity
  a_drop_at_capacity: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dropped |-> result.items_seen == SEEN_BITS'(MAX_ITEMS))
    else $error("dropped item below capacity");

  // A taken item always leaves a nonempty sequence
  a_taken_nonempty: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.dropped |-> result.items_seen != '0)
    else $error("taken item reports an empty sequence");

endmodule
